// ===== hdl/ucal_pkg.sv =====
// ----------------------------------------------------------------------------
// ucal_pkg: shared types and constants for the Unix time to calendar converter
// Word layouts, epoch and cycle lengths, reciprocals for the constant dividers.
// ----------------------------------------------------------------------------
package ucal_pkg;

  localparam int unsigned SECS_W   = 38;
  localparam int unsigned NSEC_W   = 30;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned T_W      = 39;
  localparam int unsigned DAY_W    = 22;
  localparam int unsigned SOD_W    = 17;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MS_W     = 10;

  typedef struct packed {
    logic [SECS_W-1:0] unix_seconds;
    logic [NSEC_W-1:0] nanoseconds;
  } item_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [MS_W-1:0]   millisecond;
  } result_t;

  typedef struct packed {
    logic [DAY_W-1:0] days;
    logic [SOD_W-1:0] sod;
    logic [MS_W-1:0]  ms;
  } split_t;

  typedef struct packed {
    logic [4:0]      hour;
    logic [5:0]      minute;
    logic [5:0]      second;
    logic [MS_W-1:0] ms;
  } tod_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
  } date_t;

  localparam logic [T_W-1:0] EPOCH_SECS = 39'd62135596800;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned DAY_HI_DIV    = SECS_PER_DAY >> 7;   // 675
  localparam int unsigned HOUR_HI_DIV   = 3600 >> 4;           // 225
  localparam int unsigned MIN_HI_DIV    = 60 >> 2;             // 15
  localparam int unsigned MS_DIV        = 1000000 >> 6;        // 15625
  localparam int unsigned MS_MAX        = 999;
  localparam int unsigned DAYS_400Y     = 365 * 400 + 97;
  localparam int unsigned DAYS_100Y     = 365 * 100 + 24;
  localparam int unsigned DAYS_4Y       = 365 * 4 + 1;
  localparam int unsigned DAYS_1Y       = 365;
  localparam int unsigned FEB29_DOY     = 59;
  localparam int unsigned LAST_4Y_INDEX = 24;

  // floor(2^32 / divisor): estimate is exact or one low for 32-bit dividends
  localparam logic [31:0] RCP_DAY_HI  = 32'((64'd1 << 32) / 64'(DAY_HI_DIV));
  localparam logic [31:0] RCP_HOUR_HI = 32'((64'd1 << 32) / 64'(HOUR_HI_DIV));
  localparam logic [31:0] RCP_MIN_HI  = 32'((64'd1 << 32) / 64'(MIN_HI_DIV));
  localparam logic [31:0] RCP_MS      = 32'((64'd1 << 32) / 64'(MS_DIV));
  localparam logic [31:0] RCP_400Y    = 32'((64'd1 << 32) / 64'(DAYS_400Y));
  localparam logic [31:0] RCP_4Y      = 32'((64'd1 << 32) / 64'(DAYS_4Y));

  localparam logic [8:0] MONTH_START [0:12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  localparam int unsigned DATE_STAGES = 7;
  localparam int unsigned TOD_STAGES  = 4;
  localparam int unsigned TOD_PAD     = DATE_STAGES - TOD_STAGES;

endpackage

// ===== hdl/ucal_epoch.sv =====
// ----------------------------------------------------------------------------
// ucal_epoch: zone offset, epoch shift and split into days and second of day
// Three stages; also derives the millisecond field from the nanoseconds.
// ----------------------------------------------------------------------------
module ucal_epoch (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  valid,
  input  ucal_pkg::item_t                       item,
  input  logic signed [ucal_pkg::OFFSET_W-1:0]  offset,
  output logic                                  split_valid,
  output ucal_pkg::split_t                      split
);
  import ucal_pkg::*;

  logic signed [17:0] off60;
  logic [T_W-1:0]     t_next;

  logic               s1_valid;
  logic [T_W-1:0]     s1_t;
  logic [23:0]        s1_msx;

  logic [63:0]        pd;
  logic [63:0]        pm;
  logic               s2_valid;
  logic [T_W-1:0]     s2_t;
  logic [23:0]        s2_msx;
  logic [22:0]        s2_qd;
  logic [10:0]        s2_qm;

  logic [10:0]        rd;
  logic               dhit;
  logic [10:0]        rd_fix;
  logic [14:0]        rm;
  logic               mhit;
  logic [10:0]        msq;
  split_t             split_next;

  assign off60  = 18'(offset) * 18'sd60;
  assign t_next = 39'(item.unix_seconds) + EPOCH_SECS - 39'(off60);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= valid;
    end
    s1_t   <= t_next;
    s1_msx <= item.nanoseconds[NSEC_W-1:6];
  end

  assign pd = 64'(s1_t[T_W-1:7]) * 64'(RCP_DAY_HI);
  assign pm = 64'(s1_msx) * 64'(RCP_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_t   <= s1_t;
    s2_msx <= s1_msx;
    s2_qd  <= pd[54:32];
    s2_qm  <= pm[42:32];
  end

  always_comb begin
    rd     = 11'(s2_t[T_W-1:7] - 32'(s2_qd) * 32'(DAY_HI_DIV));
    dhit   = rd >= 11'(DAY_HI_DIV);
    rd_fix = dhit ? rd - 11'(DAY_HI_DIV) : rd;
    rm     = 15'(s2_msx - 24'(s2_qm) * 24'(MS_DIV));
    mhit   = rm >= 15'(MS_DIV);
    msq    = s2_qm + 11'(mhit);
    split_next.days = DAY_W'(s2_qd + 23'(dhit));
    split_next.sod  = {rd_fix[9:0], s2_t[6:0]};
    split_next.ms   = (msq > 11'(MS_MAX)) ? MS_W'(MS_MAX) : msq[MS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split_valid <= 1'b0;
    end else begin
      split_valid <= s2_valid;
    end
    split <= split_next;
  end

endmodule

// ===== hdl/ucal_tod.sv =====
// ----------------------------------------------------------------------------
// ucal_tod: hour, minute and second from the second of day
// Four compute stages, then a delay line to line up with the date path.
// ----------------------------------------------------------------------------
module ucal_tod (
  input  logic             clk,
  input  ucal_pkg::split_t split,
  output ucal_pkg::tod_t   tod
);
  import ucal_pkg::*;

  logic [63:0]      ph;
  logic [SOD_W-1:0] t1_sod;
  logic [4:0]       t1_qh;
  logic [MS_W-1:0]  t1_ms;

  logic [8:0]       rh;
  logic             hhit;
  logic [8:0]       rh_fix;
  logic [4:0]       t2_hour;
  logic [11:0]      t2_rem;
  logic [MS_W-1:0]  t2_ms;

  logic [63:0]      pmin;
  logic [4:0]       t3_hour;
  logic [11:0]      t3_rem;
  logic [5:0]       t3_qm;
  logic [MS_W-1:0]  t3_ms;

  logic [4:0]       rmin;
  logic             mhit;
  logic [4:0]       rmin_fix;
  tod_t             t4_next;
  tod_t             pad [TOD_PAD+1];

  assign ph = 64'(split.sod[SOD_W-1:4]) * 64'(RCP_HOUR_HI);

  always_ff @(posedge clk) begin
    t1_sod <= split.sod;
    t1_qh  <= ph[36:32];
    t1_ms  <= split.ms;
  end

  always_comb begin
    rh     = 9'(t1_sod[SOD_W-1:4] - 13'(t1_qh) * 13'(HOUR_HI_DIV));
    hhit   = rh >= 9'(HOUR_HI_DIV);
    rh_fix = hhit ? rh - 9'(HOUR_HI_DIV) : rh;
  end

  always_ff @(posedge clk) begin
    t2_hour <= t1_qh + 5'(hhit);
    t2_rem  <= {rh_fix[7:0], t1_sod[3:0]};
    t2_ms   <= t1_ms;
  end

  assign pmin = 64'(t2_rem[11:2]) * 64'(RCP_MIN_HI);

  always_ff @(posedge clk) begin
    t3_hour <= t2_hour;
    t3_rem  <= t2_rem;
    t3_qm   <= pmin[37:32];
    t3_ms   <= t2_ms;
  end

  always_comb begin
    rmin     = 5'(t3_rem[11:2] - 10'(t3_qm) * 10'(MIN_HI_DIV));
    mhit     = rmin >= 5'(MIN_HI_DIV);
    rmin_fix = mhit ? rmin - 5'(MIN_HI_DIV) : rmin;
    t4_next.hour   = t3_hour;
    t4_next.minute = t3_qm + 6'(mhit);
    t4_next.second = {rmin_fix[3:0], t3_rem[1:0]};
    t4_next.ms     = t3_ms;
  end

  always_ff @(posedge clk) begin
    pad[0] <= t4_next;
    for (int i = 1; i <= TOD_PAD; i++) begin
      pad[i] <= pad[i-1];
    end
  end

  assign tod = pad[TOD_PAD];

endmodule

// ===== hdl/ucal_date.sv =====
// ----------------------------------------------------------------------------
// ucal_date: day count to Gregorian year, month and day of month
// Seven stages: 400-, 100-, 4- and 1-year cycles, then the month lookup.
// ----------------------------------------------------------------------------
module ucal_date (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  input  logic [ucal_pkg::DAY_W-1:0]  days,
  output logic                        date_valid,
  output ucal_pkg::date_t             date
);
  import ucal_pkg::*;

  logic [DATE_STAGES-1:0] vpipe;

  logic [63:0]       p1;
  logic [DAY_W-1:0]  d1_days;
  logic [4:0]        d1_q;

  logic [18:0]       r1;
  logic              hit1;
  logic [18:0]       r1_fix;
  logic [4:0]        d2_n1;
  logic [17:0]       d2_c400;

  logic [1:0]        n2;
  logic [4:0]        d3_n1;
  logic [1:0]        d3_n2;
  logic [15:0]       d3_c100;

  logic [63:0]       p3;
  logic [4:0]        d4_n1;
  logic [1:0]        d4_n2;
  logic [15:0]       d4_c100;
  logic [4:0]        d4_q3;

  logic [11:0]       r3;
  logic              hit3;
  logic [11:0]       r3_fix;
  logic [4:0]        d5_n1;
  logic [1:0]        d5_n2;
  logic [4:0]        d5_n3;
  logic [10:0]       d5_c4;

  logic [1:0]        n4;
  logic [YEAR_W-1:0] d6_year;
  logic [8:0]        d6_doy;
  logic              d6_leap;

  logic [8:0]        doy_adj;
  logic [3:0]        mcount;
  logic [8:0]        mbegin;
  date_t             date_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[DATE_STAGES-2:0], valid};
    end
  end

  assign date_valid = vpipe[DATE_STAGES-1];

  // 400-year cycles
  assign p1 = 64'(days) * 64'(RCP_400Y);

  always_ff @(posedge clk) begin
    d1_days <= days;
    d1_q    <= p1[36:32];
  end

  always_comb begin
    r1     = 19'(d1_days - 22'(d1_q) * 22'(DAYS_400Y));
    hit1   = r1 >= 19'(DAYS_400Y);
    r1_fix = hit1 ? r1 - 19'(DAYS_400Y) : r1;
  end

  always_ff @(posedge clk) begin
    d2_n1   <= d1_q + 5'(hit1);
    d2_c400 <= r1_fix[17:0];
  end

  // 100-year cycles; the last day of a 400-year cycle stays in the fourth
  always_comb begin
    if (d2_c400 >= 18'(3 * DAYS_100Y)) begin
      n2 = 2'd3;
    end else if (d2_c400 >= 18'(2 * DAYS_100Y)) begin
      n2 = 2'd2;
    end else if (d2_c400 >= 18'(DAYS_100Y)) begin
      n2 = 2'd1;
    end else begin
      n2 = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    d3_n1   <= d2_n1;
    d3_n2   <= n2;
    d3_c100 <= 16'(d2_c400 - 18'(n2) * 18'(DAYS_100Y));
  end

  // 4-year cycles
  assign p3 = 64'(d3_c100) * 64'(RCP_4Y);

  always_ff @(posedge clk) begin
    d4_n1   <= d3_n1;
    d4_n2   <= d3_n2;
    d4_c100 <= d3_c100;
    d4_q3   <= p3[36:32];
  end

  always_comb begin
    r3     = 12'(d4_c100 - 16'(d4_q3) * 16'(DAYS_4Y));
    hit3   = r3 >= 12'(DAYS_4Y);
    r3_fix = hit3 ? r3 - 12'(DAYS_4Y) : r3;
  end

  always_ff @(posedge clk) begin
    d5_n1 <= d4_n1;
    d5_n2 <= d4_n2;
    d5_n3 <= d4_q3 + 5'(hit3);
    d5_c4 <= r3_fix[10:0];
  end

  // single years; the leap day of a 4-year cycle stays in the fourth
  always_comb begin
    if (d5_c4 >= 11'(3 * DAYS_1Y)) begin
      n4 = 2'd3;
    end else if (d5_c4 >= 11'(2 * DAYS_1Y)) begin
      n4 = 2'd2;
    end else if (d5_c4 >= 11'(DAYS_1Y)) begin
      n4 = 2'd1;
    end else begin
      n4 = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    d6_doy  <= 9'(d5_c4 - 11'(n4) * 11'(DAYS_1Y));
    d6_year <= YEAR_W'(d5_n1) * YEAR_W'(400) + YEAR_W'(d5_n2) * YEAR_W'(100)
             + YEAR_W'(d5_n3) * YEAR_W'(4) + YEAR_W'(n4) + YEAR_W'(1);
    // divisible by 4 when n4 is 3, by 100 when also last 4-year block,
    // by 400 when also last century
    d6_leap <= (n4 == 2'd3) && ((d5_n3 != 5'(LAST_4Y_INDEX)) || (d5_n2 == 2'd3));
  end

  // month lookup
  always_comb begin
    doy_adj = (d6_leap && d6_doy > 9'(FEB29_DOY)) ? d6_doy - 9'd1 : d6_doy;
    mcount  = '0;
    for (int k = 1; k <= 12; k++) begin
      if (doy_adj >= MONTH_START[k]) begin
        mcount = mcount + 4'd1;
      end
    end
    mbegin = MONTH_START[mcount];
    date_next.year = d6_year;
    if (d6_leap && d6_doy == 9'(FEB29_DOY)) begin
      date_next.month        = 4'd2;
      date_next.day_of_month = 5'd29;
    end else begin
      date_next.month        = mcount + 4'd1;
      date_next.day_of_month = 5'(doy_adj - mbegin + 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    date <= date_next;
  end

endmodule

// ===== hdl/unix_seconds_to_calendar_time.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_time: Unix time to local Gregorian date and time
// Applies the zone offset, then splits into year, month, day, hour, minute,
// second and millisecond through a pipeline of constant dividers.
// ----------------------------------------------------------------------------
// One word is taken on every clock cycle in which start is high; busy is only
// high during reset. Each result appears on result with done high for one
// cycle, in order, after passing three stages for the epoch shift and day
// split, then seven for the 400/100/4/1-year cycles and the month lookup,
// each reciprocal multiply followed by its own correction stage. The
// receiver must take every result as it appears. Write offset_minutes
// through cfg_* only while no word is in flight.
module unix_seconds_to_calendar_time (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  ucal_pkg::item_t                       item,
  output logic                                  done,
  output ucal_pkg::result_t                     result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic signed [ucal_pkg::OFFSET_W-1:0]  cfg_data
);
  import ucal_pkg::*;

  logic signed [OFFSET_W-1:0] offset_minutes;
  logic                       accept;
  logic                       split_valid;
  split_t                     split;
  tod_t                       tod;
  date_t                      date;

  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_minutes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offset_minutes <= cfg_data;
    end
  end

  ucal_epoch u_epoch (
    .clk         (clk),
    .rst         (rst),
    .valid       (accept),
    .item        (item),
    .offset      (offset_minutes),
    .split_valid (split_valid),
    .split       (split)
  );

  ucal_tod u_tod (
    .clk   (clk),
    .split (split),
    .tod   (tod)
  );

  ucal_date u_date (
    .clk        (clk),
    .rst        (rst),
    .valid      (split_valid),
    .days       (split.days),
    .date_valid (done),
    .date       (date)
  );

  always_comb begin
    result.year         = date.year;
    result.month        = date.month;
    result.day_of_month = date.day_of_month;
    result.hour         = tod.hour;
    result.minute       = tod.minute;
    result.second       = tod.second;
    result.millisecond  = tod.ms;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for unix_seconds_to_calendar_time
// Drives Unix timestamps under a range of zone offsets. Each conversion is
// predicted in the bench by era, century and leap-cycle splitting and then a
// month-length walk. Every strobed result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ucal_pkg::*;

  localparam longint      YEAR1_TO_UNIX    = 64'sd62135596800;
  localparam longint      SECS_IN_DAY      = 86400;
  localparam longint      DAYS_IN_ERA      = 146097;
  localparam longint      DAYS_IN_CENTURY  = 36524;
  localparam longint      DAYS_IN_LEAP_RUN = 1461;
  localparam longint      LAST_DAY_9999    = 64'sd253402300799;
  localparam int unsigned LATENCY_SLACK    = 16;
  localparam int unsigned DRAIN_LIMIT      = 400;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned WORDS_PER_PHASE  = 170;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  item_t                             item_word = '0;
  logic                              done;
  result_t                           result_word;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic signed [OFFSET_W-1:0]        cfg_data = '0;

  result_t                           calendar_due[$];
  logic signed [OFFSET_W-1:0]        zone_offset = '0;
  int unsigned                       mismatches = 0;
  int unsigned                       checked_words = 0;
  int unsigned                       sent_words = 0;
  int unsigned                       zone_writes = 0;
  int unsigned                       burst_left = 0;
  int unsigned                       cycle_count = 0;
  result_t                           want;

  unix_seconds_to_calendar_time dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item_word),
    .done      (done),
    .result    (result_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic result_t calendar_of(input item_t w,
                                          input logic signed [OFFSET_W-1:0] zone);
    longint  local_secs;
    longint  days;
    longint  sod;
    longint  cyc;
    longint  yr;
    longint  ms;
    int      doy;
    int      mon;
    int      mlen;
    bit      leap;
    result_t r;
    local_secs = longint'({26'd0, w.unix_seconds}) + YEAR1_TO_UNIX
                 - 64'sd60 * longint'(zone);
    days = local_secs / SECS_IN_DAY;
    sod  = local_secs % SECS_IN_DAY;
    cyc  = days / DAYS_IN_ERA;
    yr   = 400 * cyc;
    days -= DAYS_IN_ERA * cyc;
    cyc  = days / DAYS_IN_CENTURY;
    if (cyc > 3) cyc = 3;
    yr   += 100 * cyc;
    days -= DAYS_IN_CENTURY * cyc;
    cyc  = days / DAYS_IN_LEAP_RUN;
    yr   += 4 * cyc;
    days -= DAYS_IN_LEAP_RUN * cyc;
    cyc  = days / 365;
    if (cyc > 3) cyc = 3;
    yr   += cyc + 1;
    days -= 365 * cyc;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    doy  = int'(days);
    for (mon = 1; mon < 12; mon++) begin
      case (mon)
        2:           mlen = leap ? 29 : 28;
        4, 6, 9, 11: mlen = 30;
        default:     mlen = 31;
      endcase
      if (doy < mlen) break;
      doy -= mlen;
    end
    ms = longint'(w.nanoseconds) / 1000000;
    if (ms > 999) ms = 999;
    r.year         = 14'(yr);
    r.month        = 4'(mon);
    r.day_of_month = 5'(doy + 1);
    r.hour         = 5'(sod / 3600);
    r.minute       = 6'((sod % 3600) / 60);
    r.second       = 6'(sod % 60);
    r.millisecond  = 10'(ms);
    return r;
  endfunction

  task automatic report_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // done and result are stable between edges; sampling at the falling edge
  // sees the word taken at the next rising edge
  always @(negedge clk) begin
    if (!rst && done === 1'b1) begin
      if (calendar_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none actual %h", $time, result_word);
      end else begin
        want = calendar_due.pop_front();
        checked_words++;
        report_field("year", want.year, result_word.year);
        report_field("month", want.month, result_word.month);
        report_field("day_of_month", want.day_of_month, result_word.day_of_month);
        report_field("hour", want.hour, result_word.hour);
        report_field("minute", want.minute, result_word.minute);
        report_field("second", want.second, result_word.second);
        report_field("millisecond", want.millisecond, result_word.millisecond);
      end
    end
  end

  task automatic post_timestamp(input logic [SECS_W-1:0] secs, input logic [NSEC_W-1:0] ns);
    item_t w;
    bit    taken;
    int unsigned gap;
    w.unix_seconds = secs;
    w.nanoseconds  = ns;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    start     <= 1'b1;
    item_word <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      if (taken) calendar_due.push_back(calendar_of(w, zone_offset));
      @(posedge clk);
    end
    burst_left--;
    sent_words++;
  endtask

  task automatic wait_drained();
    int unsigned k;
    start <= 1'b0;
    burst_left = 0;
    for (k = 0; k < DRAIN_LIMIT && calendar_due.size() != 0; k++) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic write_zone_offset(input logic signed [OFFSET_W-1:0] v);
    bit taken;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    zone_offset = v;
    zone_writes++;
  endtask

  task automatic test_reset_offset();
    post_timestamp(38'd0, 30'd0);
    post_timestamp(38'd86399, 30'd999999);
  endtask

  task automatic test_calendar_edges();
    post_timestamp(38'd31535999, 30'd1000000);
    post_timestamp(38'd951782399, 30'd999999999);
    post_timestamp(38'd951782400, 30'd1000000000);
    post_timestamp(38'd951868800, 30'h3fffffff);
    post_timestamp(38'd978307199, 30'd0);
    post_timestamp(38'd4107542399, 30'd500000000);
    post_timestamp(38'd4107542400, 30'd0);
    post_timestamp(38'd13574563200, 30'd123456789);
    post_timestamp(38'd253402300799, 30'd999999999);
    post_timestamp(38'd253402300800, 30'd0);
    post_timestamp(38'h3fffffffff, 30'h3fffffff);
    post_timestamp(38'h2aaaaaaaaa, 30'h2aaaaaaa);
    post_timestamp(38'h1555555555, 30'h15555555);
  endtask

  task automatic test_zone_extremes();
    logic signed [OFFSET_W-1:0] extremes[4];
    int unsigned i;
    extremes = '{12'sd1440, -12'sd1440, 12'sd2047, -12'sd2048};
    for (i = 0; i < 4; i++) begin
      write_zone_offset(extremes[i]);
      post_timestamp(38'd0, 30'd0);
      post_timestamp(38'd253402300799, 30'd999999999);
      post_timestamp(38'h3fffffffff, 30'h3fffffff);
    end
  endtask

  task automatic test_random_timestamps();
    int unsigned    phase;
    int unsigned    n;
    int unsigned    pause_at;
    longint         yr;
    longint         days;
    longint         secs;
    logic [NSEC_W-1:0] ns;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        write_zone_offset('0);
      else if ($urandom_range(0, 9) < 7)
        write_zone_offset(OFFSET_W'($signed($urandom_range(0, 2880)) - 1440));
      else
        write_zone_offset(OFFSET_W'($urandom));
      pause_at = $urandom_range(20, WORDS_PER_PHASE - 20);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n == pause_at) wait_drained();
        case ($urandom_range(0, 9))
          0, 1: secs = longint'(38'({$urandom, $urandom}));
          2, 3, 4: begin
            // near a year start, reaching over leap day and back into December
            yr   = $urandom_range(1971, 10000) - 1;
            days = 365 * (yr - 1969) + (yr / 4 - yr / 100 + yr / 400) - 477;
            days += $signed($urandom_range(0, 62)) - 1;
            secs = days * SECS_IN_DAY + $urandom_range(0, 86399);
          end
          5: secs = longint'($urandom_range(0, 2932896)) * SECS_IN_DAY
                    + (($urandom_range(0, 1) == 1) ? 86399 : 0);
          default: secs = longint'({$urandom, $urandom} % 64'(LAST_DAY_9999 + 1));
        endcase
        ns = ($urandom_range(0, 7) == 0) ? NSEC_W'($urandom)
                                         : NSEC_W'($urandom_range(0, 999999999));
        post_timestamp(SECS_W'(secs), ns);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_offset();
    test_calendar_edges();
    test_zone_extremes();
    test_random_timestamps();
    wait_drained();
    if (calendar_due.size() != 0) begin
      mismatches += calendar_due.size();
      $display("%0t: %0d results never arrived, expected %h actual none",
               $time, calendar_due.size(), calendar_due[0]);
    end
    $display("summary: %0d timestamps converted, %0d results checked, %0d offset writes",
             sent_words, checked_words, zone_writes);
    $display("summary: leap and century edges, ms saturation, offset extremes, random bursts");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
